>>> rtl/pcmt_pkg.sv
// ----------------------------------------------------------------------------
// pcmt_pkg
// Shared types and constants for the priority command mux with timeout.
// ----------------------------------------------------------------------------
package pcmt_pkg;

    // default sizing
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIMEOUT_BITS_DEF = 8;

    // fixed field widths
    localparam int WORD_W      = 32;
    localparam int CHAN_W      = 3;
    localparam int COUNT_W     = 4;
    localparam int TABLE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIORITY_TABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TABLE  = 2'd2;

    // item kinds
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // per-item status from the arbiter
    typedef struct packed {
        logic              forward;
        logic              changed;
        logic              active;
        logic [CHAN_W-1:0] channel;
    } status_t;

endpackage

>>> rtl/pcmt_core.sv
// ----------------------------------------------------------------------------
// pcmt_core
// Owner and countdown state with the combinational arbitration decision.
// ----------------------------------------------------------------------------
module pcmt_core #(
    parameter int NUM_CHANNELS = pcmt_pkg::NUM_CHANNELS_DEF,
    parameter int TIMEOUT_BITS = pcmt_pkg::TIMEOUT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          clear,
    input  logic                          action,
    input  logic [pcmt_pkg::CHAN_W-1:0]   channel,
    input  logic [pcmt_pkg::COUNT_W-1:0]  active_count,
    input  logic [pcmt_pkg::TABLE_W-1:0]  priority_table,
    input  logic [pcmt_pkg::TABLE_W-1:0]  timeout_table,
    output pcmt_pkg::status_t             status
);

    localparam logic [pcmt_pkg::BYTE_W-1:0] TIMEOUT_MAX =
        pcmt_pkg::BYTE_W'((1 << TIMEOUT_BITS) - 1);

    logic                              owner_valid_reg;
    logic                              owner_valid_next;
    logic [pcmt_pkg::CHAN_W-1:0]       owner_index_reg;
    logic [pcmt_pkg::CHAN_W-1:0]       owner_index_next;
    logic [NUM_CHANNELS-1:0][TIMEOUT_BITS-1:0] countdown_reg;
    logic [NUM_CHANNELS-1:0][TIMEOUT_BITS-1:0] countdown_next;

    logic [pcmt_pkg::BYTE_W-1:0] timeout_raw;
    logic [pcmt_pkg::BYTE_W-1:0] timeout_sat;
    logic [TIMEOUT_BITS-1:0]     timeout_load;
    logic [pcmt_pkg::BYTE_W-1:0] prio_new;
    logic [pcmt_pkg::BYTE_W-1:0] prio_owner;
    logic                        in_range;
    logic                        is_owner;
    logic                        forward;
    logic                        changed;

    // table lookups
    assign timeout_raw = timeout_table[{channel, 3'b000} +: pcmt_pkg::BYTE_W];
    assign prio_new    = priority_table[{channel, 3'b000} +: pcmt_pkg::BYTE_W];
    assign prio_owner  = priority_table[{owner_index_reg, 3'b000} +: pcmt_pkg::BYTE_W];

    // zero timeout acts as one, wide timeout saturates
    always_comb
    begin
        if (timeout_raw == '0)
        begin
            timeout_sat = pcmt_pkg::BYTE_W'(1);
        end
        else if (timeout_raw > TIMEOUT_MAX)
        begin
            timeout_sat = TIMEOUT_MAX;
        end
        else
        begin
            timeout_sat = timeout_raw;
        end
    end

    assign timeout_load = timeout_sat[TIMEOUT_BITS-1:0];
    assign in_range     = {1'b0, channel} < active_count;
    assign is_owner     = owner_valid_reg && (owner_index_reg == channel);

    // arbitration and timer update
    always_comb
    begin
        owner_valid_next = owner_valid_reg;
        owner_index_next = owner_index_reg;
        countdown_next   = countdown_reg;
        forward          = 1'b0;
        changed          = 1'b0;
        if (action == pcmt_pkg::ACT_COMMAND)
        begin
            if (in_range)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (channel == pcmt_pkg::CHAN_W'(i))
                    begin
                        countdown_next[i] = timeout_load;
                    end
                end
                forward = !owner_valid_reg || is_owner || (prio_new > prio_owner);
                if (forward && !is_owner)
                begin
                    owner_valid_next = 1'b1;
                    owner_index_next = channel;
                    changed          = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (countdown_reg[i] != '0)
                begin
                    countdown_next[i] = countdown_reg[i] - TIMEOUT_BITS'(1);
                    if ((countdown_reg[i] == TIMEOUT_BITS'(1)) && owner_valid_reg &&
                        (owner_index_reg == pcmt_pkg::CHAN_W'(i)))
                    begin
                        owner_valid_next = 1'b0;
                        owner_index_next = '0;
                        changed          = 1'b1;
                    end
                end
            end
        end
    end

    // status as seen after this item
    always_comb
    begin
        status.forward = forward;
        status.changed = changed;
        status.active  = owner_valid_next;
        status.channel = owner_valid_next ? owner_index_next : '0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= 1'b0;
            owner_index_reg <= '0;
            countdown_reg   <= '0;
        end
        else if (clear)
        begin
            owner_valid_reg <= 1'b0;
            owner_index_reg <= '0;
            countdown_reg   <= '0;
        end
        else if (step)
        begin
            owner_valid_reg <= owner_valid_next;
            owner_index_reg <= owner_index_next;
            countdown_reg   <= countdown_next;
        end
    end

endmodule

>>> rtl/priority_command_mux_with_timeout.sv
// ----------------------------------------------------------------------------
// priority_command_mux_with_timeout
// Result: registered, valid in the cycle after the input transfer.
// Throughput: one item per cycle; the arbiter decision and all countdowns
// update in the same cycle, and the result register lets a new item enter
// whenever the current result is taken or the register is empty.
// Reset: owner idle, countdowns stopped, all config registers zero.
// ----------------------------------------------------------------------------
module priority_command_mux_with_timeout #(
    parameter int NUM_CHANNELS = pcmt_pkg::NUM_CHANNELS_DEF,
    parameter int TIMEOUT_BITS = pcmt_pkg::TIMEOUT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [pcmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pcmt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [pcmt_pkg::CHAN_W-1:0]       channel,
    input  logic [pcmt_pkg::WORD_W-1:0]       steering_angle_bits,
    input  logic [pcmt_pkg::WORD_W-1:0]       steering_rate_bits,
    input  logic [pcmt_pkg::WORD_W-1:0]       speed_bits,
    input  logic [pcmt_pkg::WORD_W-1:0]       accel_bits,
    input  logic [pcmt_pkg::WORD_W-1:0]       jerk_bits,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              forward_valid,
    output logic [pcmt_pkg::WORD_W-1:0]       out_steering_angle,
    output logic [pcmt_pkg::WORD_W-1:0]       out_steering_rate,
    output logic [pcmt_pkg::WORD_W-1:0]       out_speed,
    output logic [pcmt_pkg::WORD_W-1:0]       out_accel,
    output logic [pcmt_pkg::WORD_W-1:0]       out_jerk,
    output logic                              owner_changed,
    output logic                              owner_active,
    output logic [pcmt_pkg::CHAN_W-1:0]       owner_channel
);

    logic [pcmt_pkg::COUNT_W-1:0] channel_count_reg;
    logic [pcmt_pkg::TABLE_W-1:0] priority_table_reg;
    logic [pcmt_pkg::TABLE_W-1:0] timeout_table_reg;
    logic [pcmt_pkg::COUNT_W-1:0] active_count;
    logic                         count_write;
    logic                         accept;
    pcmt_pkg::status_t            status;

    logic                         out_valid_reg;
    pcmt_pkg::status_t            status_reg;
    logic [pcmt_pkg::WORD_W-1:0]  angle_reg;
    logic [pcmt_pkg::WORD_W-1:0]  rate_reg;
    logic [pcmt_pkg::WORD_W-1:0]  speed_reg;
    logic [pcmt_pkg::WORD_W-1:0]  accel_reg;
    logic [pcmt_pkg::WORD_W-1:0]  jerk_reg;

    // config register decode
    always_comb
    begin
        count_write = 1'b0;
        unique case (cfg_index)
            pcmt_pkg::REG_CHANNEL_COUNT: count_write = cfg_we;
            default:                     count_write = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg  <= '0;
            priority_table_reg <= '0;
            timeout_table_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcmt_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[pcmt_pkg::COUNT_W-1:0];
                pcmt_pkg::REG_PRIORITY_TABLE:
                    priority_table_reg <= cfg_data[pcmt_pkg::TABLE_W-1:0];
                pcmt_pkg::REG_TIMEOUT_TABLE:
                    timeout_table_reg <= cfg_data[pcmt_pkg::TABLE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // clamp channel count to the built size
    assign active_count = (channel_count_reg > pcmt_pkg::COUNT_W'(NUM_CHANNELS)) ?
                          pcmt_pkg::COUNT_W'(NUM_CHANNELS) : channel_count_reg;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pcmt_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .clear          (count_write),
        .action         (action),
        .channel        (channel),
        .active_count   (active_count),
        .priority_table (priority_table_reg),
        .timeout_table  (timeout_table_reg),
        .status         (status)
    );

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            angle_reg  <= status.forward ? steering_angle_bits : '0;
            rate_reg   <= status.forward ? steering_rate_bits  : '0;
            speed_reg  <= status.forward ? speed_bits          : '0;
            accel_reg  <= status.forward ? accel_bits          : '0;
            jerk_reg   <= status.forward ? jerk_bits           : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign forward_valid      = status_reg.forward;
    assign out_steering_angle = angle_reg;
    assign out_steering_rate  = rate_reg;
    assign out_speed          = speed_reg;
    assign out_accel          = accel_reg;
    assign out_jerk           = jerk_reg;
    assign owner_changed      = status_reg.changed;
    assign owner_active       = status_reg.active;
    assign owner_channel      = status_reg.channel;

endmodule

>>> test/priority_command_mux_with_timeout_tb.sv
// ----------------------------------------------------------------------------
// priority_command_mux_with_timeout_tb
// Drives commands and ticks into the mux and predicts each result from its
// own model of owner, priorities and countdowns. Directed cases cover idle
// takeover, preemption, equal-priority rejection, expiry and channel limits.
// Random phases follow, with varied configurations and idle/stall bursts.
// ----------------------------------------------------------------------------
module priority_command_mux_with_timeout_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = pcmt_pkg::NUM_CHANNELS_DEF;
    localparam int TMO_MAX     = (1 << pcmt_pkg::TIMEOUT_BITS_DEF) - 1;
    localparam int QUIET_LIMIT = 1000;

    // index past the register list, writes are dropped
    localparam logic [pcmt_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    // word 0 angle, 1 rate, 2 speed, 3 accel, 4 jerk
    typedef logic [4:0][pcmt_pkg::WORD_W-1:0] cmd_words_t;

    typedef struct packed {
        logic                        fwd;
        cmd_words_t                  words;
        logic                        chg;
        logic                        act;
        logic [pcmt_pkg::CHAN_W-1:0] own;
    } mux_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [pcmt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pcmt_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             action = pcmt_pkg::ACT_COMMAND;
    logic [pcmt_pkg::CHAN_W-1:0]      channel = '0;
    logic [pcmt_pkg::WORD_W-1:0]      steering_angle_bits = '0;
    logic [pcmt_pkg::WORD_W-1:0]      steering_rate_bits = '0;
    logic [pcmt_pkg::WORD_W-1:0]      speed_bits = '0;
    logic [pcmt_pkg::WORD_W-1:0]      accel_bits = '0;
    logic [pcmt_pkg::WORD_W-1:0]      jerk_bits = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             forward_valid;
    logic [pcmt_pkg::WORD_W-1:0]      out_steering_angle;
    logic [pcmt_pkg::WORD_W-1:0]      out_steering_rate;
    logic [pcmt_pkg::WORD_W-1:0]      out_speed;
    logic [pcmt_pkg::WORD_W-1:0]      out_accel;
    logic [pcmt_pkg::WORD_W-1:0]      out_jerk;
    logic                             owner_changed;
    logic                             owner_active;
    logic [pcmt_pkg::CHAN_W-1:0]      owner_channel;

    // predicted arbiter state and configuration
    logic [pcmt_pkg::COUNT_W-1:0]     arb_count;
    logic [pcmt_pkg::TABLE_W-1:0]     prio_tbl;
    logic [pcmt_pkg::TABLE_W-1:0]     tmo_tbl;
    logic                             own_valid;
    logic [pcmt_pkg::CHAN_W-1:0]      own_ch;
    logic [7:0]                       countdown_q [NUM_CH];

    mux_result_t                      pending_results [$];
    int                               err_count = 0;
    int                               quiet_cycles = 0;
    bit                               idle_en = 1'b1;

    priority_command_mux_with_timeout DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .action             (action),
        .channel            (channel),
        .steering_angle_bits(steering_angle_bits),
        .steering_rate_bits (steering_rate_bits),
        .speed_bits         (speed_bits),
        .accel_bits         (accel_bits),
        .jerk_bits          (jerk_bits),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .forward_valid      (forward_valid),
        .out_steering_angle (out_steering_angle),
        .out_steering_rate  (out_steering_rate),
        .out_speed          (out_speed),
        .out_accel          (out_accel),
        .out_jerk           (out_jerk),
        .owner_changed      (owner_changed),
        .owner_active       (owner_active),
        .owner_channel      (owner_channel)
    );

    // clock
    always #6 clk = ~clk;

    // owner back to idle, all countdowns stopped
    function automatic void clear_arbiter();
        own_valid = 1'b0;
        own_ch    = '0;
        foreach (countdown_q[i])
            countdown_q[i] = '0;
    endfunction

    // arbitrate one item and advance the countdowns
    function automatic mux_result_t arbitrate_item(logic act,
                                                   logic [pcmt_pkg::CHAN_W-1:0] ch,
                                                   cmd_words_t w);
        mux_result_t r;
        int          lim;
        int          tmo;
        logic        take;
        r    = '0;
        take = 1'b0;
        lim  = (arb_count > NUM_CH) ? NUM_CH : int'(arb_count);
        if (act == pcmt_pkg::ACT_COMMAND)
        begin
            if (int'(ch) < lim)
            begin
                tmo = int'(tmo_tbl[int'(ch)*8 +: 8]);
                if (tmo == 0)
                    tmo = 1;
                if (tmo > TMO_MAX)
                    tmo = TMO_MAX;
                countdown_q[ch] = tmo[7:0];
                if (!own_valid || own_ch == ch)
                    take = 1'b1;
                else if (prio_tbl[int'(ch)*8 +: 8] > prio_tbl[int'(own_ch)*8 +: 8])
                    take = 1'b1;
                if (take && !(own_valid && own_ch == ch))
                begin
                    own_valid = 1'b1;
                    own_ch    = ch;
                    r.chg     = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (countdown_q[i] != 0)
                begin
                    countdown_q[i] = countdown_q[i] - 8'd1;
                    if (countdown_q[i] == 0 && own_valid && int'(own_ch) == i)
                    begin
                        own_valid = 1'b0;
                        own_ch    = '0;
                        r.chg     = 1'b1;
                    end
                end
            end
        end
        r.fwd = take;
        if (take)
            r.words = w;
        r.act = own_valid;
        r.own = own_valid ? own_ch : '0;
        return r;
    endfunction

    // command words, with all-zero and all-one words now and then
    function automatic cmd_words_t rand_words();
        cmd_words_t w;
        for (int i = 0; i < 5; i++)
        begin
            case ($urandom_range(0, 7))
                0:       w[i] = '0;
                1:       w[i] = '1;
                default: w[i] = $urandom();
            endcase
        end
        return w;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [pcmt_pkg::WORD_W-1:0] got,
                               logic [pcmt_pkg::WORD_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // one item on the input channel, called at a rising edge
    task automatic send_item(logic act, logic [pcmt_pkg::CHAN_W-1:0] ch, cmd_words_t w);
        int gap;
        bit taken;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        action              <= act;
        channel             <= ch;
        steering_angle_bits <= w[0];
        steering_rate_bits  <= w[1];
        speed_bits          <= w[2];
        accel_bits          <= w[3];
        jerk_bits           <= w[4];
        pending_results.push_back(arbitrate_item(act, ch, w));
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    // stop sending and wait for every result to come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [pcmt_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pcmt_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pcmt_pkg::REG_CHANNEL_COUNT:
            begin
                arb_count = d[pcmt_pkg::COUNT_W-1:0];
                clear_arbiter();
            end
            pcmt_pkg::REG_PRIORITY_TABLE: prio_tbl = d;
            pcmt_pkg::REG_TIMEOUT_TABLE:  tmo_tbl = d;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_random_item();
        logic                        act;
        logic [pcmt_pkg::CHAN_W-1:0] ch;
        int                          lim;
        lim = (arb_count > NUM_CH) ? NUM_CH : int'(arb_count);
        act = ($urandom_range(0, 9) < 3) ? pcmt_pkg::ACT_TICK : pcmt_pkg::ACT_COMMAND;
        if (lim > 0 && $urandom_range(0, 9) != 0)
            ch = pcmt_pkg::CHAN_W'($urandom_range(0, lim - 1));
        else
            ch = pcmt_pkg::CHAN_W'($urandom_range(0, 7));
        send_item(act, ch, rand_words());
    endtask

    // after reset no channel is in use, so commands are ignored
    task automatic test_power_on_defaults();
        send_item(pcmt_pkg::ACT_COMMAND, 3'd0, '1);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd7, '0);
        send_item(pcmt_pkg::ACT_TICK, 3'd0, rand_words());
        settle();
        write_reg(REG_UNMAPPED, '1);
    endtask

    // takeover from idle, same owner, lower and equal priority, preemption, expiry
    task automatic test_arbitration();
        write_reg(pcmt_pkg::REG_PRIORITY_TABLE, 64'h00_05_05_05_FF_20_20_10);
        write_reg(pcmt_pkg::REG_TIMEOUT_TABLE,  64'h01_04_04_04_FF_02_00_03);
        write_reg(pcmt_pkg::REG_CHANNEL_COUNT,  64'd8);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd0, '0);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd0, '1);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd7, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd1, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd2, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd5, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd0, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd2, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd3, '1);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd0, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd7, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd2, rand_words());
        settle();
    endtask

    // channel limit, clamped count, table rewrites keep the owner
    task automatic test_channel_range();
        write_reg(pcmt_pkg::REG_CHANNEL_COUNT, 64'd3);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd2, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd3, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd7, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd0, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd0, rand_words());
        settle();
        write_reg(pcmt_pkg::REG_CHANNEL_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd7, rand_words());
        send_item(pcmt_pkg::ACT_COMMAND, 3'd3, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd1, rand_words());
        settle();
        write_reg(pcmt_pkg::REG_PRIORITY_TABLE, '0);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd0, rand_words());
        settle();
        write_reg(pcmt_pkg::REG_TIMEOUT_TABLE, '0);
        send_item(pcmt_pkg::ACT_COMMAND, 3'd3, rand_words());
        send_item(pcmt_pkg::ACT_TICK, 3'd3, rand_words());
        settle();
    endtask

    // random traffic over several configurations, last phase at full rate
    task automatic test_random_phases();
        int                              counts [8] = '{8, 4, 1, 15, 0, 6, 8, 8};
        int                              n;
        logic [pcmt_pkg::TABLE_W-1:0]    pt;
        logic [pcmt_pkg::TABLE_W-1:0]    tt;
        logic [pcmt_pkg::CFG_DATA_W-1:0] cw;
        counts[7] = $urandom_range(1, 8);
        for (int p = 0; p < 8; p++)
        begin
            idle_en = (p != 7);
            for (int b = 0; b < 8; b++)
            begin
                pt[b*8 +: 8] = 8'((p % 2 == 1) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 3));
                tt[b*8 +: 8] = 8'(($urandom_range(0, 15) == 0) ? 255
                                                               : $urandom_range(0, 5));
            end
            write_reg(pcmt_pkg::REG_TIMEOUT_TABLE, tt);
            write_reg(pcmt_pkg::REG_PRIORITY_TABLE, pt);
            // phase 6 keeps the owner and countdowns left by phase 5
            if (p != 6)
            begin
                cw      = {$urandom(), $urandom()};
                cw[3:0] = pcmt_pkg::COUNT_W'(counts[p]);
                write_reg(pcmt_pkg::REG_CHANNEL_COUNT, cw);
            end
            n = (counts[p] == 0) ? 40 : 110;
            repeat (n) send_random_item();
            settle();
        end
    endtask

    // result side: random stall bursts while idling is on
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(negedge clk)
    begin
        mux_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_error("result transfer with nothing expected");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("forward_valid", pcmt_pkg::WORD_W'(forward_valid),
                            pcmt_pkg::WORD_W'(want.fwd));
                check_field("out_steering_angle", out_steering_angle, want.words[0]);
                check_field("out_steering_rate", out_steering_rate, want.words[1]);
                check_field("out_speed", out_speed, want.words[2]);
                check_field("out_accel", out_accel, want.words[3]);
                check_field("out_jerk", out_jerk, want.words[4]);
                check_field("owner_changed", pcmt_pkg::WORD_W'(owner_changed),
                            pcmt_pkg::WORD_W'(want.chg));
                check_field("owner_active", pcmt_pkg::WORD_W'(owner_active),
                            pcmt_pkg::WORD_W'(want.act));
                check_field("owner_channel", pcmt_pkg::WORD_W'(owner_channel),
                            pcmt_pkg::WORD_W'(want.own));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        arb_count = '0;
        prio_tbl  = '0;
        tmo_tbl   = '0;
        clear_arbiter();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_power_on_defaults();
        test_arbitration();
        test_channel_range();
        test_random_phases();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
            report_error("expected results never arrived");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/pcmt_pkg.sv
rtl/pcmt_core.sv
rtl/priority_command_mux_with_timeout.sv
test/priority_command_mux_with_timeout_tb.sv
